// ----- rtl/core/quad_arming_motor_mixer_core_assert.svh -----
// Assertion macros shared by the mixer core.
// Each check is sampled on the rising clock edge and is switched off while reset is held.
`ifndef QUAD_ARMING_MOTOR_MIXER_CORE_ASSERT_SVH
`define QUAD_ARMING_MOTOR_MIXER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QAMM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("qamm: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define QAMM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("qamm: next-cycle check failed");

`endif

// ----- rtl/core/qamm_pkg.sv -----
`default_nettype none

package qamm_pkg;

    localparam int THR_W   = 10;
    localparam int STICK_W = 10;
    localparam int CORR_W  = 11;
    localparam int SERVO_W = 10;
    localparam int PULSE_W = 12;
    localparam int PHASE_W = 2;
    localparam int SUM_W   = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 80;

    // Arming state codes.
    localparam logic [PHASE_W-1:0] PHASE_IDLE   = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_PRIMED = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_ARMED  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_CAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_OFF    = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [THR_W-1:0]   THROTTLE_CAP_RST = 10'd800;
    localparam logic [PULSE_W-1:0] PULSE_MIN_RST    = 12'd1060;
    localparam logic [PULSE_W-1:0] PULSE_MAX_RST    = 12'd2000;
    localparam logic [PULSE_W-1:0] PULSE_OFF_RST    = 12'd1000;

    // Stick thresholds of the arming machine.
    localparam logic [STICK_W-1:0] STICK_LOW  = 10'd40;
    localparam logic [STICK_W-1:0] YAW_ARM    = 10'd450;
    localparam logic [STICK_W-1:0] YAW_DISARM = 10'd950;

    localparam logic [PULSE_W-1:0] PULSE_BASE = 12'd1000;
    localparam logic [PULSE_W-1:0] SERVO_LOW  = 12'd500;
    localparam logic [PULSE_W-1:0] SERVO_HIGH = 12'd2500;

    typedef logic [PULSE_W-1:0] pulse_t;

    // Input beat, last field in the lowest bits.
    typedef struct packed {
        logic [SERVO_W-1:0]        servo_command;
        logic signed [CORR_W-1:0]  yaw_correction;
        logic signed [CORR_W-1:0]  roll_correction;
        logic signed [CORR_W-1:0]  pitch_correction;
        logic [STICK_W-1:0]        yaw_stick;
        logic [THR_W-1:0]          throttle_stick;
    } in_item_t;

    typedef struct packed {
        pulse_t front_left;
        pulse_t rear_left;
        pulse_t rear_right;
        pulse_t front_right;
    } motor_set_t;

    // Result beat, last field in the lowest bits.
    typedef struct packed {
        logic               arm_event;
        logic [PHASE_W-1:0] arm_phase;
        pulse_t             servo_falling;
        pulse_t             servo_rising;
        motor_set_t         motors;
    } out_item_t;

    // Settings that the mixer needs from the configuration registers.
    typedef struct packed {
        logic [THR_W-1:0] throttle_cap;
        pulse_t           pulse_min;
        pulse_t           pulse_max;
        pulse_t           pulse_off;
    } mix_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/qamm_motor_mix.sv -----
`default_nettype none

// X-frame mixing of throttle and the three corrections into four motor pulses.
module qamm_motor_mix (
    input  logic                                  armed,
    input  logic [qamm_pkg::THR_W-1:0]            throttle,
    input  logic signed [qamm_pkg::CORR_W-1:0]    pitch,
    input  logic signed [qamm_pkg::CORR_W-1:0]    roll,
    input  logic signed [qamm_pkg::CORR_W-1:0]    yaw,
    input  qamm_pkg::mix_cfg_t                    cfg,
    output qamm_pkg::motor_set_t                  motors
);

    localparam int SW = qamm_pkg::SUM_W;
    localparam int EXT_C = qamm_pkg::SUM_W - qamm_pkg::CORR_W;
    localparam int EXT_P = qamm_pkg::SUM_W - qamm_pkg::PULSE_W;
    localparam int EXT_T = qamm_pkg::SUM_W - qamm_pkg::THR_W;

    logic [qamm_pkg::THR_W-1:0] thr_capped;
    logic signed [SW-1:0] base_x;
    logic signed [SW-1:0] p_x;
    logic signed [SW-1:0] r_x;
    logic signed [SW-1:0] y_x;
    logic signed [SW-1:0] min_x;
    logic signed [SW-1:0] max_x;
    logic signed [SW-1:0] sum_fr;
    logic signed [SW-1:0] sum_rr;
    logic signed [SW-1:0] sum_rl;
    logic signed [SW-1:0] sum_fl;

    // Raise to the minimum first, then cut to the maximum, so the maximum wins
    // when the two limits cross.
    function automatic qamm_pkg::pulse_t clamp_pulse(
        input logic signed [SW-1:0] v,
        input logic signed [SW-1:0] lo,
        input logic signed [SW-1:0] hi
    );
        logic signed [SW-1:0] t;
        t = v;
        if (t < lo) begin
            t = lo;
        end
        if (t > hi) begin
            t = hi;
        end
        return t[qamm_pkg::PULSE_W-1:0];
    endfunction

    assign thr_capped = (throttle > cfg.throttle_cap) ? cfg.throttle_cap : throttle;

    assign base_x = $signed({{EXT_P{1'b0}}, qamm_pkg::PULSE_BASE})
                  + $signed({{EXT_T{1'b0}}, thr_capped});
    assign p_x    = $signed({{EXT_C{pitch[qamm_pkg::CORR_W-1]}}, pitch});
    assign r_x    = $signed({{EXT_C{roll[qamm_pkg::CORR_W-1]}}, roll});
    assign y_x    = $signed({{EXT_C{yaw[qamm_pkg::CORR_W-1]}}, yaw});
    assign min_x  = $signed({{EXT_P{1'b0}}, cfg.pulse_min});
    assign max_x  = $signed({{EXT_P{1'b0}}, cfg.pulse_max});

    assign sum_fr = base_x - p_x + r_x - y_x;
    assign sum_rr = base_x + p_x + r_x + y_x;
    assign sum_rl = base_x + p_x - r_x - y_x;
    assign sum_fl = base_x - p_x - r_x + y_x;

    always_comb begin
        if (armed) begin
            motors.front_right = clamp_pulse(sum_fr, min_x, max_x);
            motors.rear_right  = clamp_pulse(sum_rr, min_x, max_x);
            motors.rear_left   = clamp_pulse(sum_rl, min_x, max_x);
            motors.front_left  = clamp_pulse(sum_fl, min_x, max_x);
        end else begin
            motors.front_right = cfg.pulse_off;
            motors.rear_right  = cfg.pulse_off;
            motors.rear_left   = cfg.pulse_off;
            motors.front_left  = cfg.pulse_off;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/quad_arming_motor_mixer_core.sv -----
// Motor mixer core for an X-frame quadcopter with a stick-driven arming machine.
// One input beat on the s_ channel is one control tick: throttle and yaw sticks, the three
// PID corrections and a servo command. Each tick yields exactly one result beat on the
// m_ channel: four motor pulses, two servo pulses, the arming phase after the tick and a
// flag that marks the tick on which the machine entered the armed phase.
// The four settings (throttle cap, lowest, highest and off pulse) are written through the
// plain write port, one register per cycle, and are meant to change only while the core
// holds no unfinished tick.
// A beat that is taken sits in the input register, is mixed and lands in the result register
// once that register is free, and is offered on m_tvalid from then on.
// Throughput is one beat per cycle while m_tready is high; the arming state register is
// the only state carried from tick to tick, updated as each tick enters the result register.
// When the receiver stalls, the result is held and the input register still takes one more
// beat; s_tready falls only when both registers are full and m_tready is low.
// Reset clears both valid flags, returns the arming machine to idle and reloads the
// settings with their default values.
`default_nettype none

module quad_arming_motor_mixer_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Configuration write port.
    input  logic                                  cfg_wr_en,
    input  logic [qamm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [qamm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // Input channel.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // From bit 0: throttle_stick[9:0], yaw_stick[19:10], pitch_correction[30:20],
    // roll_correction[41:31], yaw_correction[52:42], servo_command[62:53], zero [63].
    input  logic [qamm_pkg::IN_TDATA_W-1:0]       s_tdata,
    // Result channel.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // From bit 0: motor_front_right[11:0], motor_rear_right[23:12],
    // motor_rear_left[35:24], motor_front_left[47:36], servo_rising[59:48],
    // servo_falling[71:60], arm_phase[73:72], arm_event[74], zeros [79:75].
    output logic [qamm_pkg::OUT_TDATA_W-1:0]      m_tdata
);

    `include "quad_arming_motor_mixer_core_assert.svh"

    localparam int IN_W  = $bits(qamm_pkg::in_item_t);
    localparam int OUT_W = $bits(qamm_pkg::out_item_t);

    // Settings.
    logic [qamm_pkg::THR_W-1:0] throttle_cap_reg, throttle_cap_next;
    qamm_pkg::pulse_t           pulse_min_reg, pulse_min_next;
    qamm_pkg::pulse_t           pulse_max_reg, pulse_max_next;
    qamm_pkg::pulse_t           pulse_off_reg, pulse_off_next;

    // Pipeline registers.
    logic                 in_valid_reg, in_valid_next;
    qamm_pkg::in_item_t   in_item_reg;
    logic                 res_valid_reg, res_valid_next;
    qamm_pkg::out_item_t  res_reg;
    logic [qamm_pkg::PHASE_W-1:0] arm_state_reg, arm_state_next;

    logic                 s_accept;
    logic                 res_free;
    logic                 advance;
    logic                 thr_low;
    logic [qamm_pkg::PHASE_W-1:0] phase_a;
    logic [qamm_pkg::PHASE_W-1:0] phase_b;
    logic [qamm_pkg::PHASE_W-1:0] phase_c;
    logic                 event_c;
    qamm_pkg::mix_cfg_t   mix_cfg;
    qamm_pkg::motor_set_t motors;
    qamm_pkg::out_item_t  res_next;

    // Handshake: the result register frees itself when taken, and the input register
    // empties into it whenever it is free.
    assign res_free = !res_valid_reg || m_tready;
    assign advance  = in_valid_reg && res_free;
    assign s_tready = !in_valid_reg || res_free;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept || (in_valid_reg && !res_free);
    assign res_valid_next = advance || (res_valid_reg && !m_tready);

    always_comb begin
        throttle_cap_next = throttle_cap_reg;
        pulse_min_next    = pulse_min_reg;
        pulse_max_next    = pulse_max_reg;
        pulse_off_next    = pulse_off_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                qamm_pkg::REG_THROTTLE_CAP: begin
                    throttle_cap_next = cfg_wdata[qamm_pkg::THR_W-1:0];
                end
                qamm_pkg::REG_PULSE_MIN: begin
                    pulse_min_next = cfg_wdata[qamm_pkg::PULSE_W-1:0];
                end
                qamm_pkg::REG_PULSE_MAX: begin
                    pulse_max_next = cfg_wdata[qamm_pkg::PULSE_W-1:0];
                end
                qamm_pkg::REG_PULSE_OFF: begin
                    pulse_off_next = cfg_wdata[qamm_pkg::PULSE_W-1:0];
                end
                default: begin
                    throttle_cap_next = throttle_cap_reg;
                end
            endcase
        end
    end

    // The three arming checks run in order, each one seeing the phase left by the one
    // before, so a primed machine may arm and disarm again within a single tick.
    always_comb begin
        thr_low = in_item_reg.throttle_stick < qamm_pkg::STICK_LOW;

        phase_a = arm_state_reg;
        if (arm_state_reg == qamm_pkg::PHASE_IDLE && thr_low
                && in_item_reg.yaw_stick < qamm_pkg::STICK_LOW) begin
            phase_a = qamm_pkg::PHASE_PRIMED;
        end

        phase_b = phase_a;
        event_c = 1'b0;
        if (phase_a == qamm_pkg::PHASE_PRIMED && thr_low
                && in_item_reg.yaw_stick > qamm_pkg::YAW_ARM) begin
            phase_b = qamm_pkg::PHASE_ARMED;
            event_c = 1'b1;
        end

        phase_c = phase_b;
        if (phase_b == qamm_pkg::PHASE_ARMED && thr_low
                && in_item_reg.yaw_stick > qamm_pkg::YAW_DISARM) begin
            phase_c = qamm_pkg::PHASE_IDLE;
        end
    end

    assign arm_state_next = advance ? phase_c : arm_state_reg;

    assign mix_cfg.throttle_cap = throttle_cap_reg;
    assign mix_cfg.pulse_min    = pulse_min_reg;
    assign mix_cfg.pulse_max    = pulse_max_reg;
    assign mix_cfg.pulse_off    = pulse_off_reg;

    qamm_motor_mix u_mix (
        .armed    (phase_c == qamm_pkg::PHASE_ARMED),
        .throttle (in_item_reg.throttle_stick),
        .pitch    (in_item_reg.pitch_correction),
        .roll     (in_item_reg.roll_correction),
        .yaw      (in_item_reg.yaw_correction),
        .cfg      (mix_cfg),
        .motors   (motors)
    );

    // Servo pulses wrap to twelve bits, which covers every ten-bit command.
    always_comb begin
        res_next.motors        = motors;
        res_next.servo_rising  = qamm_pkg::SERVO_LOW
                               + {1'b0, in_item_reg.servo_command, 1'b0};
        res_next.servo_falling = qamm_pkg::SERVO_HIGH
                               - {1'b0, in_item_reg.servo_command, 1'b0};
        res_next.arm_phase     = phase_c;
        res_next.arm_event     = event_c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            res_valid_reg    <= 1'b0;
            arm_state_reg    <= qamm_pkg::PHASE_IDLE;
            throttle_cap_reg <= qamm_pkg::THROTTLE_CAP_RST;
            pulse_min_reg    <= qamm_pkg::PULSE_MIN_RST;
            pulse_max_reg    <= qamm_pkg::PULSE_MAX_RST;
            pulse_off_reg    <= qamm_pkg::PULSE_OFF_RST;
        end else begin
            in_valid_reg     <= in_valid_next;
            res_valid_reg    <= res_valid_next;
            arm_state_reg    <= arm_state_next;
            throttle_cap_reg <= throttle_cap_next;
            pulse_min_reg    <= pulse_min_next;
            pulse_max_reg    <= pulse_max_next;
            pulse_off_reg    <= pulse_off_next;
        end
    end

    // Payload registers carry no reset; the valid flags guard them.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= qamm_pkg::in_item_t'(s_tdata[IN_W-1:0]);
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {{(qamm_pkg::OUT_TDATA_W-OUT_W){1'b0}}, res_reg};

    // The stored arming state always matches the phase reported by the newest result.
    `QAMM_ASSERT_NEXT(a_state_follows_result, aclk, aresetn, advance, arm_state_reg == res_reg.arm_phase)
    // An arming event ends either armed or, after an immediate disarm, idle.
    `QAMM_ASSERT_IMP(a_event_not_primed, aclk, aresetn, m_tvalid && res_reg.arm_event, res_reg.arm_phase != qamm_pkg::PHASE_PRIMED)
    // Outside the armed phase every motor gets the off pulse; front right and rear left are checked.
    `QAMM_ASSERT_IMP(a_off_when_disarmed, aclk, aresetn, m_tvalid && res_reg.arm_phase != qamm_pkg::PHASE_ARMED, res_reg.motors.front_right == pulse_off_reg && res_reg.motors.rear_left == pulse_off_reg)
    // The armed rear right pulse stays within the limits whenever the limits are ordered.
    `QAMM_ASSERT_IMP(a_armed_in_range, aclk, aresetn, m_tvalid && res_reg.arm_phase == qamm_pkg::PHASE_ARMED && pulse_min_reg <= pulse_max_reg, res_reg.motors.rear_right >= pulse_min_reg && res_reg.motors.rear_right <= pulse_max_reg)

endmodule

`default_nettype wire

// ----- sim/quad_mixer_checker.sv -----
module quad_mixer_checker
    import qamm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    output int                     fail_count,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the settings and of the arming machine.
    logic [THR_W-1:0]   cap_q;
    pulse_t             min_q;
    pulse_t             max_q;
    pulse_t             off_q;
    logic [PHASE_W-1:0] phase_q;

    out_item_t expected_ticks[$];
    out_item_t want;
    out_item_t got;

    function automatic pulse_t clamp_motor(int level);
        int v;
        v = level;
        if (v < int'(min_q)) v = int'(min_q);
        if (v > int'(max_q)) v = int'(max_q);
        return pulse_t'(v);
    endfunction

    // Runs one control tick through the arming machine and the mixer.
    function automatic out_item_t mix_tick(in_item_t tick);
        out_item_t          res;
        int                 thr;
        int                 base;
        int                 p;
        int                 r;
        int                 y;
        logic               low;
        logic [PHASE_W-1:0] ph;
        thr = int'(tick.throttle_stick);
        p = int'($signed(tick.pitch_correction));
        r = int'($signed(tick.roll_correction));
        y = int'($signed(tick.yaw_correction));
        low = thr < int'(STICK_LOW);
        res = '0;
        ph = phase_q;
        if (ph == PHASE_IDLE && low && tick.yaw_stick < STICK_LOW) ph = PHASE_PRIMED;
        if (ph == PHASE_PRIMED && low && tick.yaw_stick > YAW_ARM) begin
            ph = PHASE_ARMED;
            res.arm_event = 1'b1;
        end
        if (ph == PHASE_ARMED && low && tick.yaw_stick > YAW_DISARM) ph = PHASE_IDLE;
        phase_q = ph;
        if (ph == PHASE_ARMED) begin
            if (thr > int'(cap_q)) thr = int'(cap_q);
            base = int'(PULSE_BASE) + thr;
            res.motors.front_right = clamp_motor(base - p + r - y);
            res.motors.rear_right  = clamp_motor(base + p + r + y);
            res.motors.rear_left   = clamp_motor(base + p - r - y);
            res.motors.front_left  = clamp_motor(base - p - r + y);
        end else begin
            res.motors = {4{off_q}};
        end
        res.servo_rising  = pulse_t'(int'(SERVO_LOW) + 2 * int'(tick.servo_command));
        res.servo_falling = pulse_t'(int'(SERVO_HIGH) - 2 * int'(tick.servo_command));
        res.arm_phase = ph;
        return res;
    endfunction

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cap_q = THROTTLE_CAP_RST;
            min_q = PULSE_MIN_RST;
            max_q = PULSE_MAX_RST;
            off_q = PULSE_OFF_RST;
            phase_q = PHASE_IDLE;
            expected_ticks.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_THROTTLE_CAP: cap_q = cfg_wdata[THR_W-1:0];
                    REG_PULSE_MIN:    min_q = cfg_wdata[PULSE_W-1:0];
                    REG_PULSE_MAX:    max_q = cfg_wdata[PULSE_W-1:0];
                    REG_PULSE_OFF:    off_q = cfg_wdata[PULSE_W-1:0];
                    default: ;
                endcase
            end
            // The result side is checked before the new tick is queued; since a tick is registered
            // before it can be offered as a result, the two can never be the same beat.
            if (m_tvalid && m_tready) begin
                if (expected_ticks.size() == 0) begin
                    $error("result beat arrived with no tick outstanding");
                    fail_count++;
                end else begin
                    want = expected_ticks.pop_front();
                    got = m_tdata[$bits(out_item_t)-1:0];
                    check_field("motor_front_right", want.motors.front_right,
                                got.motors.front_right);
                    check_field("motor_rear_right", want.motors.rear_right,
                                got.motors.rear_right);
                    check_field("motor_rear_left", want.motors.rear_left,
                                got.motors.rear_left);
                    check_field("motor_front_left", want.motors.front_left,
                                got.motors.front_left);
                    check_field("servo_rising", want.servo_rising, got.servo_rising);
                    check_field("servo_falling", want.servo_falling, got.servo_falling);
                    check_field("arm_phase", want.arm_phase, got.arm_phase);
                    check_field("arm_event", want.arm_event, got.arm_event);
                end
            end
            if (s_tvalid && s_tready) begin
                expected_ticks.push_back(mix_tick(s_tdata[$bits(in_item_t)-1:0]));
            end
        end
        pending = expected_ticks.size();
    end

endmodule

// ----- sim/testbench.sv -----
module testbench;
    import qamm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any beat on either channel before the run is declared hung.
    // The longest deliberate silence is the receiver hold-off below; random stalls
    // at 57 per cent are much shorter.
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 6;
    localparam int TICKS_PER_PHASE = 150;

    // Stick gestures used to build flights: priming, arming, flying and disarming.
    typedef enum int {
        GEST_ANY,
        GEST_PRIME,
        GEST_ARM,
        GEST_FLY,
        GEST_DISARM
    } gesture_e;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;
    bit hold_req;

    quad_arming_motor_mixer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    quad_mixer_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 12 ns clock, starting low so that the first rising edge is well defined.
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Receiver. Each falling edge decides afresh whether the next rising edge may
    // take a result beat. When a hold-off is requested, tready is kept low for a
    // long stretch counted here, so that the core fills both of its registers and
    // has to push back on the sender.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: any beat, configuration write or reset cycle counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one tick on the input channel, preceded by random idle cycles, and
    // returns at the falling edge after the beat was taken. tvalid is left high so
    // that a following tick goes out back to back.
    task automatic send_tick(in_item_t tick);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata <= {$urandom, $urandom};
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= IN_TDATA_W'(tick);
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_fields(int thr, int yaw, int pitch, int roll, int yaw_corr,
                               int servo);
        in_item_t tick;
        tick.throttle_stick   = THR_W'(thr);
        tick.yaw_stick        = STICK_W'(yaw);
        tick.pitch_correction = CORR_W'(pitch);
        tick.roll_correction  = CORR_W'(roll);
        tick.yaw_correction   = CORR_W'(yaw_corr);
        tick.servo_command    = SERVO_W'(servo);
        send_tick(tick);
    endtask

    // Corrections are mostly moderate, so that armed pulses often land between
    // the limits, with a share spread over the whole signed range.
    function automatic logic signed [CORR_W-1:0] rand_correction();
        if ($urandom_range(3) == 0) return CORR_W'($urandom);
        return CORR_W'(int'($urandom_range(400)) - 200);
    endfunction

    function automatic in_item_t rand_tick(gesture_e gesture);
        in_item_t tick;
        tick.throttle_stick   = THR_W'($urandom_range(1023));
        tick.yaw_stick        = STICK_W'($urandom_range(1023));
        tick.pitch_correction = rand_correction();
        tick.roll_correction  = rand_correction();
        tick.yaw_correction   = rand_correction();
        tick.servo_command    = ($urandom_range(9) == 0) ? SERVO_W'($urandom_range(1023))
                                                         : SERVO_W'($urandom_range(1000));
        case (gesture)
            GEST_PRIME: begin
                tick.throttle_stick = THR_W'($urandom_range(39));
                tick.yaw_stick = STICK_W'($urandom_range(39));
            end
            GEST_ARM: begin
                // Yaw above the disarm threshold here arms and disarms in one tick.
                tick.throttle_stick = THR_W'($urandom_range(39));
                tick.yaw_stick = STICK_W'($urandom_range(1023, 451));
            end
            GEST_FLY: begin
                if ($urandom_range(7) != 0) tick.throttle_stick = THR_W'($urandom_range(1023, 40));
            end
            GEST_DISARM: begin
                tick.throttle_stick = THR_W'($urandom_range(39));
                tick.yaw_stick = STICK_W'($urandom_range(1023, 951));
            end
            default: ;
        endcase
        return tick;
    endfunction

    // Mostly complete flights (prime, arm, a few armed ticks, often a disarm) with
    // random content, mixed with fully random ticks.
    task automatic run_flights(int count);
        int sent;
        int airborne;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 70) begin
                send_tick(rand_tick(GEST_PRIME));
                send_tick(rand_tick(GEST_ARM));
                airborne = $urandom_range(8);
                repeat (airborne) send_tick(rand_tick(GEST_FLY));
                sent += 2 + airborne;
                if ($urandom_range(99) < 60) begin
                    send_tick(rand_tick(GEST_DISARM));
                    sent++;
                end
            end else begin
                send_tick(rand_tick(GEST_ANY));
                sent++;
            end
        end
    endtask

    // Settings may only change while the core holds no tick, so the sender stops
    // and every outstanding result is collected first.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic apply_settings(int cap, int lo, int hi, int off);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_THROTTLE_CAP;
        cfg_wdata <= CFG_DATA_W'(cap);
        @(negedge aclk);
        cfg_index <= REG_PULSE_MIN;
        cfg_wdata <= CFG_DATA_W'(lo);
        @(negedge aclk);
        cfg_index <= REG_PULSE_MAX;
        cfg_wdata <= CFG_DATA_W'(hi);
        @(negedge aclk);
        cfg_index <= REG_PULSE_OFF;
        cfg_wdata <= CFG_DATA_W'(off);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        quiet_cycles = 0;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed ticks under the reset settings, walking the arming machine
        // through every transition and its threshold boundaries.
        send_fields(500, 512, 0, 0, 0, 500);              // idle, sticks not low
        send_fields(0, 0, 0, 0, 0, 0);                    // idle to primed
        send_fields(39, 451, 100, -50, 25, 1000);         // primed to armed, event
        send_fields(1023, 503, -1024, -1024, -1024, 1023); // capped throttle, servo above 1000
        send_fields(1023, 503, 1023, 1023, 1023, 0);      // pulses pushed to both limits
        send_fields(900, 500, 1023, -1024, 1023, 250);
        send_fields(39, 951, 0, 0, 0, 1);                 // armed to idle
        send_fields(40, 0, 5, 5, 5, 999);                 // throttle exactly at the threshold
        send_fields(0, 40, -5, -5, -5, 1000);             // yaw exactly at the threshold
        send_fields(0, 39, 0, 0, 0, 2);                   // idle to primed
        send_fields(0, 450, 0, 0, 0, 3);                  // yaw at the arm threshold, stays primed
        send_fields(0, 950, 300, -300, 200, 4);           // arms, yaw at the disarm threshold
        send_fields(0, 950, -700, 600, -500, 5);          // stays armed
        send_fields(40, 1023, 0, 0, 0, 6);                // disarm yaw but throttle not low
        send_fields(0, 1023, 0, 0, 0, 7);                 // disarmed
        send_fields(0, 0, 0, 0, 0, 8);                    // primed again
        send_fields(0, 1023, 512, -512, 7, 999);          // arm and disarm in the same tick
        send_fields(0, 0, 0, 0, 0, 9);                    // primed
        send_fields(0, 0, 0, 0, 0, 10);                   // primed stays primed
        send_fields(0, 451, -1, 1, -1, 11);               // armed
        send_fields(1023, 1023, -1024, 1023, -1024, 1023); // high throttle keeps it armed
        send_fields(0, 1023, 0, 0, 0, 12);                // disarmed

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain();
            case (phase)
                0: begin
                    // Widest limits, with the off pulse at its top.
                    apply_settings(1023, 0, 4095, 4095);
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    // Minimum above maximum: every armed motor sits on the maximum.
                    apply_settings(0, 4095, 0, 0);
                    send_idle_pct = 57;
                    recv_stall_pct = 0;
                end
                2: begin
                    apply_settings(int'(THROTTLE_CAP_RST), int'(PULSE_MIN_RST),
                                   int'(PULSE_MAX_RST), int'(PULSE_OFF_RST));
                    send_idle_pct = 0;
                    recv_stall_pct = 57;
                    hold_req = 1'b1;
                end
                3: begin
                    apply_settings($urandom_range(1023), $urandom_range(1500),
                                   $urandom_range(4095, 1500), $urandom_range(4095));
                    send_idle_pct = 24;
                    recv_stall_pct = 24;
                end
                4: begin
                    apply_settings(512, 1200, 1800, 1);
                    send_idle_pct = 0;
                    recv_stall_pct = 57;
                end
                default: begin
                    apply_settings($urandom_range(1023), $urandom_range(4095),
                                   $urandom_range(4095), $urandom_range(4095));
                    send_idle_pct = 24;
                    recv_stall_pct = 24;
                end
            endcase
            run_flights(TICKS_PER_PHASE);
        end

        // Collect the last results, then wait for any stray beat.
        drain();
        repeat (8) @(negedge aclk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
